FILE: sv/quadratic_root_solver_macros.svh
// Assertion helpers shared by the solver RTL.
`ifndef QUADRATIC_ROOT_SOLVER_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define QRS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("quadratic_root_solver: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define QRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("quadratic_root_solver: next-cycle check failed");

`endif

FILE: sv/qrs_pkg.sv
`default_nettype none

package qrs_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int TOL_W     = 31;
    localparam int PROD_W    = 2 * WORD_BITS;
    localparam int D_W       = 2 * WORD_BITS + 1;
    localparam int SQ_STEPS  = WORD_BITS + 1;
    localparam int X_W       = 2 * SQ_STEPS;
    localparam int ROOT_W    = SQ_STEPS;
    localparam int REM_W     = ROOT_W + 3;
    localparam int BASE_W    = WORD_BITS + 1;
    localparam int DEN_W     = WORD_BITS + 1;
    localparam int NUM_W     = ROOT_W + 2;
    localparam int DIV_STEPS = WORD_BITS;
    localparam int HI_SH     = WORD_BITS - FRAC_BITS;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);
    localparam logic             REG_TOLERANCE = 1'b0;

    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;
    localparam logic [1:0] CNT_INF  = 2'd3;

    localparam logic [WORD_BITS-1:0] MIN_MAG = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic [WORD_BITS-1:0] MAX_MAG = {1'b0, {(WORD_BITS-1){1'b1}}};

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_LIN,
        KIND_ONE,
        KIND_TWO
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [1:0] count;
    } ctl_t;

    typedef struct packed {
        logic                        a_small;
        logic                        b_small;
        logic                        c_small;
        logic                        sign_diff;
        logic [WORD_BITS-1:0]        ma;
        logic [WORD_BITS-1:0]        mb;
        logic [WORD_BITS-1:0]        mc;
        logic signed [BASE_W-1:0]    base;
        logic signed [DEN_W-1:0]     den;
    } s1_t;

    typedef struct packed {
        logic                        a_small;
        logic                        b_small;
        logic                        c_small;
        logic                        sign_diff;
        logic [PROD_W-1:0]           p;
        logic [PROD_W-1:0]           m;
        logic signed [BASE_W-1:0]    base;
        logic signed [DEN_W-1:0]     den;
    } s2_t;

    typedef struct packed {
        logic                        a_small;
        logic                        b_small;
        logic                        c_small;
        logic                        has;
        logic [D_W-1:0]              d;
        logic signed [BASE_W-1:0]    base;
        logic signed [DEN_W-1:0]     den;
    } s3_t;

    typedef struct packed {
        ctl_t                        ctl;
        logic signed [BASE_W-1:0]    base;
        logic signed [DEN_W-1:0]     den;
        logic [X_W-1:0]              x;
        logic [REM_W-1:0]            rem;
        logic [ROOT_W-1:0]           root;
    } sq_t;

    typedef struct packed {
        logic                        neg;
        logic                        sat;
        logic [DEN_W-1:0]            rem;
        logic [DEN_W-1:0]            md;
        logic [WORD_BITS-1:0]        lo;
        logic [WORD_BITS-1:0]        q;
    } dv_t;

    typedef struct packed {
        ctl_t ctl;
        dv_t  l0;
        dv_t  l1;
    } dp_t;

    typedef struct packed {
        logic                        ovf;
        logic [WORD_BITS-1:0]        r;
    } res_t;

    typedef struct packed {
        logic [1:0]                  count;
        logic [WORD_BITS-1:0]        rm;
        logic [WORD_BITS-1:0]        rp;
        logic                        ovf;
    } out_t;

    function automatic sq_t sq_step(input sq_t s);
        sq_t o;
        logic [REM_W+1:0] r2;
        logic [REM_W+1:0] t;
        o  = s;
        r2 = {s.rem, s.x[X_W-1 -: 2]};
        t  = (REM_W+2)'({s.root, 2'b01});
        if (r2 >= t)
        begin
            o.rem  = REM_W'(r2 - t);
            o.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            o.rem  = REM_W'(r2);
            o.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        o.x = {s.x[X_W-3:0], 2'b00};
        return o;
    endfunction

    function automatic dv_t dv_prep(input logic signed [NUM_W-1:0] num,
                                    input logic signed [DEN_W-1:0] den);
        dv_t o;
        logic [NUM_W-1:0] mn;
        logic [DEN_W-1:0] md;
        logic [NUM_W-1:0] hi;
        logic [NUM_W-1:0] sh;
        logic             zero;
        mn     = num[NUM_W-1] ? (~num + 1'b1) : num;
        md     = den[DEN_W-1] ? (~den + 1'b1) : den;
        zero   = (md == '0);
        hi     = mn >> HI_SH;
        sh     = mn << FRAC_BITS;
        o.sat  = zero || (hi >= NUM_W'(md));
        o.neg  = zero ? num[NUM_W-1] : (num[NUM_W-1] ^ den[DEN_W-1]);
        o.rem  = DEN_W'(hi);
        o.md   = md;
        o.lo   = sh[WORD_BITS-1:0];
        o.q    = '0;
        return o;
    endfunction

    function automatic dv_t dv_step(input dv_t l);
        dv_t o;
        logic [DEN_W:0] r2;
        logic [DEN_W:0] mdx;
        logic           qb;
        o   = l;
        r2  = {l.rem, l.lo[WORD_BITS-1]};
        mdx = {1'b0, l.md};
        if (r2 >= mdx)
        begin
            o.rem = DEN_W'(r2 - mdx);
            qb    = 1'b1;
        end
        else
        begin
            o.rem = DEN_W'(r2);
            qb    = 1'b0;
        end
        o.lo = {l.lo[WORD_BITS-2:0], 1'b0};
        o.q  = {l.q[WORD_BITS-2:0], qb};
        return o;
    endfunction

    function automatic res_t lane_result(input dv_t l);
        res_t                 o;
        logic [WORD_BITS-1:0] lim;
        logic [WORD_BITS-1:0] qm;
        logic                 sat;
        lim   = l.neg ? MIN_MAG : MAX_MAG;
        sat   = l.sat || (l.q > lim);
        qm    = sat ? lim : l.q;
        o.ovf = sat;
        o.r   = l.neg ? ('0 - qm) : qm;
        return o;
    endfunction

endpackage

`default_nettype wire

FILE: sv/quadratic_root_solver.sv
// Quadratic root solver for signed Q16.16 coefficients a, b, c. Each request gives one
// result: root_count (0 none, 1 one, 2 two, 3 infinitely many), root_minus, root_plus and
// an overflow flag for roots saturated to the Q16.16 range. A new request is taken every
// cycle while coef_stall is low. The path runs through four front stages for magnitudes,
// the 32x32 products, the discriminant and classification, then the 33-stage floored
// square root (one result bit per stage), one divider setup stage, two 32-stage restoring
// dividers (one quotient bit per stage) and the result register. A two-entry output
// (result register plus skid) keeps requests flowing while root_stall is high, and the
// whole pipe holds once the skid fills. The tolerance register sits at byte address 0 of
// the APB port.
`default_nettype none
`include "quadratic_root_solver_macros.svh"

module quadratic_root_solver (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    psel,
    input  wire logic                                    penable,
    input  wire logic                                    pwrite,
    input  wire logic [qrs_pkg::ADDR_W-1:0]              paddr,
    input  wire logic [qrs_pkg::DATA_W-1:0]              pwdata,
    output logic      [qrs_pkg::DATA_W-1:0]              prdata,
    output logic                                         pready,
    input  wire logic                                    coef_valid,
    output logic                                         coef_stall,
    input  wire logic signed [qrs_pkg::WORD_BITS-1:0]    coef_a,
    input  wire logic signed [qrs_pkg::WORD_BITS-1:0]    coef_b,
    input  wire logic signed [qrs_pkg::WORD_BITS-1:0]    coef_c,
    output logic                                         root_valid,
    input  wire logic                                    root_stall,
    output logic [1:0]                                   root_count,
    output logic signed [qrs_pkg::WORD_BITS-1:0]         root_minus,
    output logic signed [qrs_pkg::WORD_BITS-1:0]         root_plus,
    output logic                                         overflow
);

    logic [qrs_pkg::TOL_W-1:0] tol_reg;

    logic            s1_vld_reg, s2_vld_reg, s3_vld_reg;
    qrs_pkg::s1_t    s1_reg, s1_next;
    qrs_pkg::s2_t    s2_reg, s2_next;
    qrs_pkg::s3_t    s3_reg, s3_next;
    logic            sq_vld_reg [0:qrs_pkg::SQ_STEPS];
    qrs_pkg::sq_t    sq_reg     [0:qrs_pkg::SQ_STEPS];
    qrs_pkg::sq_t    sq0_next;
    logic            dv_vld_reg [0:qrs_pkg::DIV_STEPS];
    qrs_pkg::dp_t    dv_reg     [0:qrs_pkg::DIV_STEPS];
    qrs_pkg::dp_t    dv0_next;
    qrs_pkg::out_t   fin_next;
    qrs_pkg::out_t   out_reg, skid_reg;
    logic            root_valid_reg, skid_vld_reg;
    logic            en, accept, tol_wr, last_vld;

    assign pready = 1'b1;
    assign tol_wr = psel && penable && pwrite && pready && (paddr[2] == qrs_pkg::REG_TOLERANCE);
    assign prdata = (paddr[2] == qrs_pkg::REG_TOLERANCE) ?
                    qrs_pkg::DATA_W'(tol_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= qrs_pkg::TOL_RESET;
        end
        else if (tol_wr)
        begin
            tol_reg <= pwdata[qrs_pkg::TOL_W-1:0];
        end
    end

    assign en         = !skid_vld_reg;
    assign coef_stall = skid_vld_reg;
    assign accept     = coef_valid && !coef_stall;
    assign last_vld   = dv_vld_reg[qrs_pkg::DIV_STEPS];

    always_comb
    begin
        logic [qrs_pkg::WORD_BITS-1:0] ma, mb, mc, tz;
        logic signed [qrs_pkg::BASE_W-1:0] b_ext, c_ext;
        ma    = coef_a[qrs_pkg::WORD_BITS-1] ? ('0 - coef_a) : coef_a;
        mb    = coef_b[qrs_pkg::WORD_BITS-1] ? ('0 - coef_b) : coef_b;
        mc    = coef_c[qrs_pkg::WORD_BITS-1] ? ('0 - coef_c) : coef_c;
        tz    = qrs_pkg::WORD_BITS'(tol_reg);
        b_ext = qrs_pkg::BASE_W'(coef_b);
        c_ext = qrs_pkg::BASE_W'(coef_c);
        s1_next.a_small   = ma < tz;
        s1_next.b_small   = mb < tz;
        s1_next.c_small   = mc < tz;
        s1_next.sign_diff = coef_a[qrs_pkg::WORD_BITS-1] ^ coef_c[qrs_pkg::WORD_BITS-1];
        s1_next.ma        = ma;
        s1_next.mb        = mb;
        s1_next.mc        = mc;
        s1_next.base      = s1_next.a_small ? -c_ext : -b_ext;
        s1_next.den       = s1_next.a_small ? b_ext : {coef_a, 1'b0};
    end

    always_comb
    begin
        s2_next.a_small   = s1_reg.a_small;
        s2_next.b_small   = s1_reg.b_small;
        s2_next.c_small   = s1_reg.c_small;
        s2_next.sign_diff = s1_reg.sign_diff;
        s2_next.p         = s1_reg.mb * s1_reg.mb;
        s2_next.m         = s1_reg.ma * s1_reg.mc;
        s2_next.base      = s1_reg.base;
        s2_next.den       = s1_reg.den;
    end

    always_comb
    begin
        logic [qrs_pkg::D_W-1:0] p, q;
        p = qrs_pkg::D_W'(s2_reg.p);
        q = qrs_pkg::D_W'({s2_reg.m, 2'b00});
        s3_next.a_small = s2_reg.a_small;
        s3_next.b_small = s2_reg.b_small;
        s3_next.c_small = s2_reg.c_small;
        s3_next.base    = s2_reg.base;
        s3_next.den     = s2_reg.den;
        if (s2_reg.sign_diff)
        begin
            s3_next.has = 1'b1;
            s3_next.d   = p + q;
        end
        else
        begin
            s3_next.has = p >= q;
            s3_next.d   = p - q;
        end
    end

    always_comb
    begin
        logic [qrs_pkg::D_W-1:0] tsc;
        tsc = qrs_pkg::D_W'({tol_reg, {qrs_pkg::FRAC_BITS{1'b0}}});
        sq0_next.base = s3_reg.base;
        sq0_next.den  = s3_reg.den;
        sq0_next.x    = qrs_pkg::X_W'(s3_reg.d);
        sq0_next.rem  = '0;
        sq0_next.root = '0;
        if (s3_reg.a_small)
        begin
            if (s3_reg.b_small)
            begin
                sq0_next.ctl.kind  = qrs_pkg::KIND_NONE;
                sq0_next.ctl.count = s3_reg.c_small ? qrs_pkg::CNT_INF : qrs_pkg::CNT_NONE;
            end
            else
            begin
                sq0_next.ctl.kind  = qrs_pkg::KIND_LIN;
                sq0_next.ctl.count = qrs_pkg::CNT_ONE;
            end
        end
        else if (!s3_reg.has)
        begin
            sq0_next.ctl.kind  = qrs_pkg::KIND_NONE;
            sq0_next.ctl.count = qrs_pkg::CNT_NONE;
        end
        else if (s3_reg.d < tsc)
        begin
            sq0_next.ctl.kind  = qrs_pkg::KIND_ONE;
            sq0_next.ctl.count = qrs_pkg::CNT_ONE;
        end
        else
        begin
            sq0_next.ctl.kind  = qrs_pkg::KIND_TWO;
            sq0_next.ctl.count = qrs_pkg::CNT_TWO;
        end
    end

    always_comb
    begin
        logic signed [qrs_pkg::NUM_W-1:0] base, s, num0, num1;
        base = qrs_pkg::NUM_W'(sq_reg[qrs_pkg::SQ_STEPS].base);
        s    = signed'(qrs_pkg::NUM_W'(sq_reg[qrs_pkg::SQ_STEPS].root));
        num0 = (sq_reg[qrs_pkg::SQ_STEPS].ctl.kind == qrs_pkg::KIND_TWO) ? (base - s) : base;
        num1 = base + s;
        dv0_next.ctl = sq_reg[qrs_pkg::SQ_STEPS].ctl;
        dv0_next.l0  = qrs_pkg::dv_prep(num0, sq_reg[qrs_pkg::SQ_STEPS].den);
        dv0_next.l1  = qrs_pkg::dv_prep(num1, sq_reg[qrs_pkg::SQ_STEPS].den);
    end

    always_comb
    begin
        qrs_pkg::res_t r0, r1;
        qrs_pkg::kind_t k;
        r0 = qrs_pkg::lane_result(dv_reg[qrs_pkg::DIV_STEPS].l0);
        r1 = qrs_pkg::lane_result(dv_reg[qrs_pkg::DIV_STEPS].l1);
        k  = dv_reg[qrs_pkg::DIV_STEPS].ctl.kind;
        fin_next.count = dv_reg[qrs_pkg::DIV_STEPS].ctl.count;
        fin_next.rm    = (k != qrs_pkg::KIND_NONE) ? r0.r : '0;
        fin_next.rp    = (k == qrs_pkg::KIND_TWO) ? r1.r : '0;
        fin_next.ovf   = ((k != qrs_pkg::KIND_NONE) && r0.ovf) ||
                         ((k == qrs_pkg::KIND_TWO) && r1.ovf);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            for (int i = 0; i <= qrs_pkg::SQ_STEPS; i++)
            begin
                sq_vld_reg[i] <= 1'b0;
            end
            for (int i = 0; i <= qrs_pkg::DIV_STEPS; i++)
            begin
                dv_vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            s1_vld_reg    <= accept;
            s2_vld_reg    <= s1_vld_reg;
            s3_vld_reg    <= s2_vld_reg;
            sq_vld_reg[0] <= s3_vld_reg;
            for (int i = 0; i < qrs_pkg::SQ_STEPS; i++)
            begin
                sq_vld_reg[i+1] <= sq_vld_reg[i];
            end
            dv_vld_reg[0] <= sq_vld_reg[qrs_pkg::SQ_STEPS];
            for (int i = 0; i < qrs_pkg::DIV_STEPS; i++)
            begin
                dv_vld_reg[i+1] <= dv_vld_reg[i];
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg    <= s1_next;
            s2_reg    <= s2_next;
            s3_reg    <= s3_next;
            sq_reg[0] <= sq0_next;
            for (int i = 0; i < qrs_pkg::SQ_STEPS; i++)
            begin
                sq_reg[i+1] <= qrs_pkg::sq_step(sq_reg[i]);
            end
            dv_reg[0] <= dv0_next;
            for (int i = 0; i < qrs_pkg::DIV_STEPS; i++)
            begin
                dv_reg[i+1].ctl <= dv_reg[i].ctl;
                dv_reg[i+1].l0  <= qrs_pkg::dv_step(dv_reg[i].l0);
                dv_reg[i+1].l1  <= qrs_pkg::dv_step(dv_reg[i].l1);
            end
        end
    end

    // output register and skid control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_valid_reg <= 1'b0;
            skid_vld_reg   <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (!root_valid_reg || !root_stall)
            begin
                root_valid_reg <= 1'b1;
                skid_vld_reg   <= 1'b0;
            end
        end
        else if (last_vld)
        begin
            if (!root_valid_reg || !root_stall)
            begin
                root_valid_reg <= 1'b1;
            end
            else
            begin
                skid_vld_reg <= 1'b1;
            end
        end
        else if (!root_stall)
        begin
            root_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (!root_valid_reg || !root_stall)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (last_vld)
        begin
            if (!root_valid_reg || !root_stall)
            begin
                out_reg <= fin_next;
            end
            else
            begin
                skid_reg <= fin_next;
            end
        end
    end

    assign root_valid = root_valid_reg;
    assign root_count = out_reg.count;
    assign root_minus = out_reg.rm;
    assign root_plus  = out_reg.rp;
    assign overflow   = out_reg.ovf;

    `QRS_ASSERT_NOW(a_skid_behind_out, skid_vld_reg, root_valid_reg)
    `QRS_ASSERT_NEXT(a_skid_catches, root_valid_reg && root_stall && !skid_vld_reg && last_vld, skid_vld_reg)
    `QRS_ASSERT_NOW(a_no_root_zero, root_valid_reg && (root_count == qrs_pkg::CNT_NONE || root_count == qrs_pkg::CNT_INF), root_minus == '0 && root_plus == '0 && !overflow)
    `QRS_ASSERT_NOW(a_plus_only_two, root_valid_reg && root_count != qrs_pkg::CNT_TWO, root_plus == '0)

endmodule

`default_nettype wire
